/* sv/rtie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtie_pkg: shared types and constants for the R-type instruction executor
// Opcodes, status codes, field widths and controller/datapath command types.
// ----------------------------------------------------------------------------
package rtie_pkg;

    localparam int REG_COUNT_DEF  = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W     = 5;
    localparam int IDX_W    = 5;
    localparam int SH_W     = 5;
    localparam int PC_W     = 32;
    localparam int CH_W     = 9;
    localparam int STAT_W   = 2;
    localparam int COUT_W   = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 88;
    localparam logic [IDX_W-1:0] LINK_REG = 5'd31;

    localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 5'd3;
    localparam logic [OP_W-1:0] OP_AND  = 5'd4;
    localparam logic [OP_W-1:0] OP_OR   = 5'd5;
    localparam logic [OP_W-1:0] OP_XOR  = 5'd6;
    localparam logic [OP_W-1:0] OP_NOR  = 5'd7;
    localparam logic [OP_W-1:0] OP_SLT  = 5'd8;
    localparam logic [OP_W-1:0] OP_SLL  = 5'd9;
    localparam logic [OP_W-1:0] OP_SRL  = 5'd10;
    localparam logic [OP_W-1:0] OP_SRA  = 5'd11;
    localparam logic [OP_W-1:0] OP_SLLV = 5'd12;
    localparam logic [OP_W-1:0] OP_SRLV = 5'd13;
    localparam logic [OP_W-1:0] OP_SRAV = 5'd14;
    localparam logic [OP_W-1:0] OP_MFHI = 5'd15;
    localparam logic [OP_W-1:0] OP_MFLO = 5'd16;
    localparam logic [OP_W-1:0] OP_JR   = 5'd17;
    localparam logic [OP_W-1:0] OP_JRAL = 5'd18;
    localparam logic [OP_W-1:0] OP_PUT  = 5'd19;
    localparam logic [OP_W-1:0] OP_GET  = 5'd20;
    localparam logic [OP_W-1:0] OP_EXIT = 5'd21;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXIT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat, start operand reads
        logic exec;      // operands ready: execute op or start multiply
        logic mul_step;  // second multiply stage
        logic div_start; // seed divider
        logic div_step;  // one quotient bit
        logic div_done;  // commit quotient/remainder
        logic pop;       // result taken
    } rtie_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic div_last;
    } rtie_stat_t;

endpackage

/* sv/rtie_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtie_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/rtie_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtie_ctrl: sequencing state machine
// Clears the register file after reset, then walks each instruction through
// read, execute, multiply/divide and result hand-off.
// ----------------------------------------------------------------------------
module rtie_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_fire,
    input  rtie_pkg::rtie_stat_t st,
    input  logic                clr_done,
    output rtie_pkg::rtie_cmd_t cmd,
    output logic                busy,
    output logic                clearing
);
    import rtie_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DEND = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLR:
            begin
                if (clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (st.is_mul)
                begin
                    cmd.exec = 1'b1;
                    state_next = S_MUL;
                end
                else if (st.is_div && !st.div_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                    state_next = S_DEND;
            end
            S_DEND:
            begin
                cmd.div_done = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    cmd.pop = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign clearing = (state_reg == S_CLR);
endmodule

/* sv/rtie_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtie_dp: execute datapath
// Register file in three RAM copies (one per read port), HI/LO, ALU,
// two-stage multiplier and radix-2 restoring divider.
// ----------------------------------------------------------------------------
module rtie_dp #(
    parameter int REG_COUNT  = rtie_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = rtie_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rtie_pkg::rtie_cmd_t          cmd,
    input  logic                         clearing,
    input  logic [rtie_pkg::IN_TDATA_W-1:0]  in_data,
    output rtie_pkg::rtie_stat_t         st,
    output logic                         clr_done,
    output logic [rtie_pkg::OUT_TDATA_W-1:0] out_data
);
    import rtie_pkg::*;

    localparam int AW = $clog2(REG_COUNT);
    localparam int CW = $clog2(DATA_WIDTH);
    localparam int HW = DATA_WIDTH / 2;

    // captured instruction
    logic [OP_W-1:0]       op_reg;
    logic [AW-1:0]         rd_reg, ra_reg, rb_reg;
    logic [SH_W-1:0]       sh_reg;
    logic [DATA_WIDTH-1:0] pc_reg;
    logic [CH_W-1:0]       ch_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_data[4:0];
            rd_reg <= in_data[5 +: AW];
            ra_reg <= in_data[10 +: AW];
            rb_reg <= in_data[15 +: AW];
            sh_reg <= in_data[24:20];
            pc_reg <= in_data[56:25];
            ch_reg <= in_data[65:57];
        end
    end

    // clearing sweep counter
    logic [AW:0] clr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clearing && !clr_reg[AW])
            clr_reg <= clr_reg + 1'b1;
    end
    assign clr_done = clr_reg[AW];

    // register file write port, shared by all copies
    logic                  wr_en;
    logic [AW-1:0]         wr_idx;
    logic [DATA_WIDTH-1:0] wr_val;
    logic                  rf_we;
    logic [AW-1:0]         rf_wa;
    logic [DATA_WIDTH-1:0] rf_wd;
    logic [DATA_WIDTH-1:0] a, b, d;
    logic [AW-1:0]         ra_addr, rb_addr, rd_addr;

    assign rf_we = clearing ? !clr_reg[AW] : (cmd.exec && wr_en);
    assign rf_wa = clearing ? clr_reg[AW-1:0] : wr_idx;
    assign rf_wd = clearing ? '0 : wr_val;
    assign ra_addr = in_data[10 +: AW];
    assign rb_addr = in_data[15 +: AW];
    assign rd_addr = in_data[5 +: AW];

    rtie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_a (
        .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
        .raddr(ra_addr), .rdata(a));
    rtie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_b (
        .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
        .raddr(rb_addr), .rdata(b));
    rtie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_d (
        .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
        .raddr(rd_addr), .rdata(d));

    // HI/LO
    logic [DATA_WIDTH-1:0] hi_reg, lo_reg, hi_next, lo_next;

    // ALU, non-multiply/divide ops
    logic [CW-1:0]         vsh;
    logic [DATA_WIDTH-1:0] res;
    logic [STAT_W-1:0]     status;
    logic                  jmp, cval;

    assign vsh = b[CW-1:0];

    always_comb
    begin
        res    = '0;
        wr_en  = 1'b0;
        wr_idx = rd_reg;
        wr_val = '0;
        status = ST_OK;
        jmp    = 1'b0;
        cval   = 1'b0;
        case (op_reg)
            OP_ADD:  begin res = a + b; wr_en = 1'b1; end
            OP_SUB:  begin res = a - b; wr_en = 1'b1; end
            OP_AND:  begin res = a & b; wr_en = 1'b1; end
            OP_OR:   begin res = a | b; wr_en = 1'b1; end
            OP_XOR:  begin res = a ^ b; wr_en = 1'b1; end
            OP_NOR:  begin res = ~(a | b); wr_en = 1'b1; end
            OP_SLT:
            begin
                res = {{(DATA_WIDTH-1){1'b0}}, ($signed(a) < $signed(b))};
                wr_en = 1'b1;
            end
            OP_SLL:  begin res = a << sh_reg; wr_en = 1'b1; end
            OP_SRL:  begin res = a >> sh_reg; wr_en = 1'b1; end
            OP_SRA:  begin res = $unsigned($signed(a) >>> sh_reg); wr_en = 1'b1; end
            OP_SLLV: begin res = a << vsh; wr_en = 1'b1; end
            OP_SRLV: begin res = a >> vsh; wr_en = 1'b1; end
            OP_SRAV: begin res = $unsigned($signed(a) >>> vsh); wr_en = 1'b1; end
            OP_MFHI: begin res = hi_reg; wr_en = 1'b1; end
            OP_MFLO: begin res = lo_reg; wr_en = 1'b1; end
            OP_GET:
            begin
                res = {{(DATA_WIDTH-CH_W){ch_reg[CH_W-1]}}, ch_reg};
                wr_en = 1'b1;
            end
            OP_JR:   jmp = 1'b1;
            OP_JRAL:
            begin
                jmp = 1'b1;
                wr_en = 1'b1;
                wr_idx = LINK_REG;
                res = pc_reg;
            end
            OP_PUT:  cval = 1'b1;
            OP_EXIT: status = ST_EXIT;
            OP_DIV:  status = (a == '0) ? ST_DIV0 : ST_OK;
            default: ;
        endcase
        wr_val = res;
    end

    assign st.is_mul   = (op_reg == OP_MUL);
    assign st.is_div   = (op_reg == OP_DIV);
    assign st.div_zero = (a == '0);

    // multiplier: four 16x16 partial products registered, summed next cycle
    logic [DATA_WIDTH-1:0] ma, mb;
    logic                  sgn_reg;
    logic [DATA_WIDTH-1:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic [2*DATA_WIDTH-1:0] mag, prod;

    assign ma = d[DATA_WIDTH-1] ? (~d + 1'b1) : d;
    assign mb = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            sgn_reg <= d[DATA_WIDTH-1] ^ a[DATA_WIDTH-1];
            pll_reg <= ma[HW-1:0] * mb[HW-1:0];
            plh_reg <= ma[HW-1:0] * mb[DATA_WIDTH-1:HW];
            phl_reg <= ma[DATA_WIDTH-1:HW] * mb[HW-1:0];
            phh_reg <= ma[DATA_WIDTH-1:HW] * mb[DATA_WIDTH-1:HW];
        end
    end

    assign mag = {phh_reg, pll_reg}
               + ({{DATA_WIDTH{1'b0}}, plh_reg} << HW)
               + ({{DATA_WIDTH{1'b0}}, phl_reg} << HW);
    assign prod = sgn_reg ? (~mag + 1'b1) : mag;

    // divider on magnitudes, one quotient bit per cycle
    logic [DATA_WIDTH-1:0] dq_reg, dr_reg, dv_reg;
    logic [CW:0]           dcnt_reg;
    logic                  qneg_reg, rneg_reg;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] qfix, rfix;

    assign trial = {dr_reg, dq_reg[DATA_WIDTH-1]} - {1'b0, dv_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg   <= ma;
            dr_reg   <= '0;
            dv_reg   <= mb;
            dcnt_reg <= '0;
            qneg_reg <= d[DATA_WIDTH-1] ^ a[DATA_WIDTH-1];
            rneg_reg <= d[DATA_WIDTH-1];
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (!trial[DATA_WIDTH])
            begin
                dr_reg <= trial[DATA_WIDTH-1:0];
                dq_reg <= {dq_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= {dr_reg[DATA_WIDTH-2:0], dq_reg[DATA_WIDTH-1]};
                dq_reg <= {dq_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign st.div_last = (dcnt_reg == (CW+1)'(DATA_WIDTH - 1));
    assign qfix = qneg_reg ? (~dq_reg + 1'b1) : dq_reg;
    assign rfix = rneg_reg ? (~dr_reg + 1'b1) : dr_reg;

    // HI/LO update
    always_comb
    begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (cmd.mul_step)
        begin
            hi_next = prod[2*DATA_WIDTH-1:DATA_WIDTH];
            lo_next = prod[DATA_WIDTH-1:0];
        end
        else if (cmd.div_done)
        begin
            hi_next = rfix;
            lo_next = qfix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    // result beat fields
    logic [OUT_TDATA_W-1:0] out_next;
    always_comb
    begin
        out_next = '0;
        out_next[1:0]   = status;
        out_next[2]     = wr_en;
        out_next[7:3]   = wr_en ? wr_idx : '0;
        out_next[39:8]  = wr_en ? wr_val : '0;
        out_next[40]    = jmp;
        // jral with rd=31 reads back the freshly linked pc
        out_next[72:41] = !jmp ? '0 :
            ((op_reg == OP_JRAL && rd_reg == LINK_REG) ? pc_reg : d);
        out_next[73]    = cval;
        out_next[81:74] = cval ? d[7:0] : '0;
    end

    // result register
    logic [OUT_TDATA_W-1:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.exec || cmd.div_start)
            out_reg <= out_next;
    end
    assign out_data = out_reg;
endmodule

/* sv/r_type_instruction_executor.sv */
`timescale 1ns / 1ps
// Sequence: the input beat is captured and the operands read, then most ops
//   execute; mul adds a second multiply stage, div runs one quotient bit per cycle in the shared divider.
// Flow: one instruction in flight; next beat accepted the cycle after the
//   result is taken.
// Reset: async active low; a sweep then zeroes the register file
//   before the first input beat is accepted. HI/LO clear at once.
// ----------------------------------------------------------------------------
// r_type_instruction_executor: top level
// Streams R-type instructions in, one result beat out per instruction.
// ----------------------------------------------------------------------------
module r_type_instruction_executor #(
    parameter int REG_COUNT  = rtie_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = rtie_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode[4:0] dest_reg[9:5] src_a[14:10] src_b[19:15] shift_amount[24:20]
    // pc_next[56:25] char_in[65:57]
    input  logic [rtie_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0] reg_write[2] write_index[7:3] write_value[39:8]
    // jump_taken[40] jump_target[72:41] char_valid[73] char_out[81:74]
    output logic [rtie_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rtie_pkg::*;

    rtie_cmd_t  cmd;
    rtie_stat_t st;
    logic busy, clearing, clr_done, valid_reg;

    // hold valid from result load until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.exec && !st.is_mul)
            valid_reg <= 1'b1;
        else if (cmd.mul_step || cmd.div_done)
            valid_reg <= 1'b1;
        else if (cmd.pop)
            valid_reg <= 1'b0;
    end

    assign s_axis_tready = !busy;
    assign m_axis_tvalid = valid_reg;

    rtie_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .st(st), .clr_done(clr_done),
        .cmd(cmd), .busy(busy), .clearing(clearing));

    rtie_dp #(.REG_COUNT(REG_COUNT), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .clearing(clearing),
        .in_data(s_axis_tdata), .st(st), .clr_done(clr_done),
        .out_data(m_axis_tdata));
endmodule

/* sv/rtie_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtie_props: port-level checks for the executor
// Handshake and result-field consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module rtie_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    // one instruction in flight: no new beat while a result waits
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no register write reported without reg_write
    a_widx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[39:3] == '0)
        else $error("write fields without reg_write");

    // status never takes the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status");
endmodule

bind r_type_instruction_executor rtie_props u_rtie_props (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));

/* test/rtie_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtie_checker: result checker for the R-type instruction executor
// Watches both stream channels, keeps a shadow register file with HI/LO,
// works out the result beat of every accepted instruction and compares the
// result beats field by field in order.
// ----------------------------------------------------------------------------
module rtie_checker
    import rtie_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [OUT_TDATA_W-1:0] out_data,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [7:0]  char_out;
        logic        char_valid;
        logic [31:0] jump_target;
        logic        jump_taken;
        logic [31:0] write_value;
        logic [4:0]  write_index;
        logic        reg_write;
        logic [1:0]  status;
    } exec_result_t;

    logic [31:0]  shadow_regs [32];
    logic [31:0]  shadow_hi;
    logic [31:0]  shadow_lo;
    exec_result_t result_queue[$];

    assign pending = result_queue.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Execute one instruction on the shadow state and return its result beat.
    function automatic exec_result_t execute(input logic [IN_TDATA_W-1:0] beat);
        logic [4:0]         op;
        logic [4:0]         rd;
        logic [4:0]         ra;
        logic [4:0]         rb;
        logic [4:0]         sh;
        logic [31:0]        pc;
        logic signed [8:0]  ch;
        logic [31:0]        a;
        logic [31:0]        b;
        logic [31:0]        d;
        logic [31:0]        res;
        logic signed [63:0] prod;
        exec_result_t       r;
        op = beat[4:0];
        rd = beat[9:5];
        ra = beat[14:10];
        rb = beat[19:15];
        sh = beat[24:20];
        pc = beat[56:25];
        ch = beat[65:57];
        a = shadow_regs[ra];
        b = shadow_regs[rb];
        d = shadow_regs[rd];
        r = '0;
        res = '0;
        r.reg_write = 1'b1;
        case (op)
            OP_ADD:  res = a + b;
            OP_SUB:  res = a - b;
            OP_AND:  res = a & b;
            OP_OR:   res = a | b;
            OP_XOR:  res = a ^ b;
            OP_NOR:  res = ~(a | b);
            OP_SLT:  res = {31'd0, $signed(a) < $signed(b)};
            OP_SLL:  res = a << sh;
            OP_SRL:  res = a >> sh;
            OP_SRA:  res = $signed(a) >>> sh;
            OP_SLLV: res = a << b[4:0];
            OP_SRLV: res = a >> b[4:0];
            OP_SRAV: res = $signed(a) >>> b[4:0];
            OP_MFHI: res = shadow_hi;
            OP_MFLO: res = shadow_lo;
            OP_GET:  res = {{23{ch[8]}}, ch};
            default: r.reg_write = 1'b0;
        endcase
        case (op)
            OP_MUL:
            begin
                prod = $signed({{32{d[31]}}, d}) * $signed({{32{a[31]}}, a});
                shadow_hi = prod[63:32];
                shadow_lo = prod[31:0];
            end
            OP_DIV:
            begin
                if (a == 0)
                    r.status = ST_DIV0;
                else if (d == 32'h8000_0000 && a == 32'hFFFF_FFFF)
                begin
                    // most negative over minus one wraps
                    shadow_lo = 32'h8000_0000;
                    shadow_hi = '0;
                end
                else
                begin
                    shadow_lo = $signed(d) / $signed(a);
                    shadow_hi = $signed(d) % $signed(a);
                end
            end
            OP_JR:
            begin
                r.jump_taken = 1'b1;
                r.jump_target = d;
            end
            OP_JRAL:
            begin
                // link first, then read the target
                shadow_regs[LINK_REG] = pc;
                r.reg_write = 1'b1;
                r.write_index = LINK_REG;
                r.write_value = pc;
                r.jump_taken = 1'b1;
                r.jump_target = shadow_regs[rd];
            end
            OP_PUT:
            begin
                r.char_valid = 1'b1;
                r.char_out = d[7:0];
            end
            OP_EXIT: r.status = ST_EXIT;
            default: ;
        endcase
        if (r.reg_write && op != OP_JRAL)
        begin
            shadow_regs[rd] = res;
            r.write_index = rd;
            r.write_value = res;
        end
        return r;
    endfunction

    // Predict on input beats, compare on output beats.
    always @(posedge clk or negedge rst_n)
    begin
        exec_result_t got;
        exec_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                shadow_regs[i] = '0;
            shadow_hi = '0;
            shadow_lo = '0;
            result_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                result_queue.push_back(execute(in_data));
            if (out_valid && out_ready)
            begin
                got = out_data[$bits(exec_result_t)-1:0];
                if (result_queue.size() == 0)
                    report("unexpected beat", 32'd0, 32'd0);
                else
                begin
                    want = result_queue.pop_front();
                    if (got.status !== want.status)
                        report("status", got.status, want.status);
                    if (got.reg_write !== want.reg_write)
                        report("reg_write", got.reg_write, want.reg_write);
                    if (got.write_index !== want.write_index)
                        report("write_index", got.write_index, want.write_index);
                    if (got.write_value !== want.write_value)
                        report("write_value", got.write_value, want.write_value);
                    if (got.jump_taken !== want.jump_taken)
                        report("jump_taken", got.jump_taken, want.jump_taken);
                    if (got.jump_target !== want.jump_target)
                        report("jump_target", got.jump_target, want.jump_target);
                    if (got.char_valid !== want.char_valid)
                        report("char_valid", got.char_valid, want.char_valid);
                    if (got.char_out !== want.char_out)
                        report("char_out", got.char_out, want.char_out);
                end
            end
        end
    end

endmodule

/* test/tb_r_type_instruction_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_r_type_instruction_executor: testbench top for the instruction executor
// Drives a directed program and then random instruction streams with random
// gaps on both channels; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_r_type_instruction_executor;
    import rtie_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    int                     fail_count;
    int                     pending;
    int                     cycle_count;

    r_type_instruction_executor dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rtie_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Short gaps mostly, a long one now and then, none in some stretches.
    function automatic int gap_len(input bit busy_phase);
        int r;
        r = $urandom_range(0, 99);
        if (busy_phase || r < 50)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one instruction and hold it until accepted; drop valid over a gap.
    task automatic send_instr(input logic [4:0] op, input logic [4:0] rd, input logic [4:0] ra,
                              input logic [4:0] rb, input logic [4:0] sh,
                              input logic [31:0] pc, input logic [8:0] ch, input bit busy);
        int n;
        n = gap_len(busy);
        @(negedge clk);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tdata <= {6'd0, ch, pc, sh, rb, ra, rd, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [8:0] rand_char();
        return ($urandom_range(0, 9) == 0) ? 9'h1FF : 9'($urandom_range(0, 511));
    endfunction

    // Receiver: random backpressure, short stalls mostly, a long one now and then.
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = gap_len($urandom_range(0, 3) == 0);
            if (n > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        bit          busy;
        logic [4:0]  op;
        logic [31:0] v;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: load extremes with get, then every operation at least once.
        send_instr(OP_GET, 5'd1, 5'd0, 5'd0, 5'd0, 32'd0, 9'h1FF, 1'b0);    // end of input
        send_instr(OP_GET, 5'd2, 5'd0, 5'd0, 5'd0, 32'd0, 9'h0FF, 1'b0);
        send_instr(OP_SLL, 5'd3, 5'd1, 5'd0, 5'd31, 32'd0, 9'd0, 1'b0);     // 0x80000000
        send_instr(OP_SRL, 5'd4, 5'd1, 5'd0, 5'd1, 32'd0, 9'd0, 1'b0);      // 0x7FFFFFFF
        send_instr(OP_ADD, 5'd5, 5'd4, 5'd2, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_SUB, 5'd6, 5'd3, 5'd2, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_MUL, 5'd3, 5'd3, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_MFHI, 5'd7, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_MFLO, 5'd8, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_DIV, 5'd3, 5'd1, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);      // most negative / -1
        send_instr(OP_MFLO, 5'd9, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_DIV, 5'd4, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);      // divide by zero
        send_instr(OP_MFHI, 5'd10, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_AND, 5'd11, 5'd1, 5'd2, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_OR, 5'd12, 5'd3, 5'd2, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_XOR, 5'd13, 5'd1, 5'd4, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_NOR, 5'd14, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_SLT, 5'd15, 5'd3, 5'd4, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_SRA, 5'd16, 5'd3, 5'd0, 5'd31, 32'd0, 9'd0, 1'b0);
        send_instr(OP_SLLV, 5'd17, 5'd2, 5'd1, 5'd0, 32'd0, 9'd0, 1'b0);    // count 31 from -1
        send_instr(OP_SRAV, 5'd18, 5'd3, 5'd2, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_SRLV, 5'd0, 5'd1, 5'd2, 5'd0, 32'd0, 9'd0, 1'b0);     // register zero writable
        send_instr(OP_JRAL, 5'd31, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, 9'd0, 1'b0); // link, read r31
        send_instr(OP_JR, 5'd0, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_PUT, 5'd2, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(OP_EXIT, 5'd0, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0, 1'b0);
        send_instr(5'd31, 5'd1, 5'd2, 5'd3, 5'd0, 32'd0, 9'd0, 1'b0);       // unused opcode

        // Random: mostly valid opcodes, sometimes a burst with no gaps.
        busy = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                busy = !busy;
            op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(22, 31))
                                              : 5'($urandom_range(0, 21));
            if (op == OP_DIV && $urandom_range(0, 2) == 0)
                op = OP_GET;   // keep divides from dominating run time
            v = $urandom;
            send_instr(op, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                       (op == OP_JRAL) ? rand_word() : v, rand_char(), busy);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
